// ===== design/earliest_deadline_task_scheduler_defines.svh =====
// Assertion helpers shared by the scheduler RTL.
`ifndef EARLIEST_DEADLINE_TASK_SCHEDULER_DEFINES_SVH
`define EARLIEST_DEADLINE_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define EDTS_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define EDTS_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/edts_pkg.sv =====
`timescale 1ns / 1ps

package edts_pkg;

    localparam int MAX_PERIODIC_DEF  = 8;
    localparam int MAX_APERIODIC_DEF = 8;
    localparam int TIME_BITS_DEF     = 16;

    localparam int WORK_W     = 16;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 4;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int MISS_W     = 8;
    localparam int CODE_W     = 2;
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_APERIODIC_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIM_LENGTH       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_APERIODIC_WINDOW = 2'd3;

    localparam logic [CFG_W-1:0] SIM_LENGTH_RESET       = 16'hFFFF;
    localparam logic [CFG_W-1:0] APERIODIC_WINDOW_RESET = 16'd500;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    localparam logic [CODE_W-1:0] SW_SAME   = 2'd0;
    localparam logic [CODE_W-1:0] SW_FIRST  = 2'd1;
    localparam logic [CODE_W-1:0] SW_IDLE   = 2'd2;
    localparam logic [CODE_W-1:0] SW_SWITCH = 2'd3;

    localparam logic [1:0] PREV_PENDING = 2'd0;
    localparam logic [1:0] PREV_IDLE    = 2'd1;
    localparam logic [1:0] PREV_TASK    = 2'd2;

endpackage

// ===== design/earliest_deadline_task_scheduler.sv =====
`timescale 1ns / 1ps
// Channel   | Signals                                  | Beat content
// ----------+------------------------------------------+-------------------------------------
// input     | s_axis_tvalid/tready/tdata/tuser         | one load or one tick item
// output    | m_axis_tvalid/tready/tdata               | one result per tick inside the run
// config    | cfg_valid/cfg_ready/cfg_index/cfg_data   | one register write
//
// A tick walks the periodic table and then the aperiodic table through one read port each,
// one slot per cycle, then updates the work left of the chosen task, if any, and reads
// the work left of the task that ran before it.
// A periodic load runs a bit-serial remainder of the tick number; an aperiodic load is
// written straight from idle. Reset clears control state and active bits only.
// A stalled output holds the finished result; the next item is taken meanwhile.

`include "earliest_deadline_task_scheduler_defines.svh"

module earliest_deadline_task_scheduler #(
    parameter int MAX_PERIODIC  = edts_pkg::MAX_PERIODIC_DEF,
    parameter int MAX_APERIODIC = edts_pkg::MAX_APERIODIC_DEF,
    parameter int TIME_BITS     = edts_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // slot_index, work_amount, period_or_release, zero pad
    input  logic [edts_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // action, slot_aperiodic
    input  logic [edts_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tick_time, run_valid, run_aperiodic, run_slot, switch_code, preempt_valid,
    // preempt_aperiodic, preempt_slot, preempt_left, finish_valid, miss_mask, zero pad
    output logic [edts_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [edts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [edts_pkg::CFG_W-1:0]      cfg_data
);

    localparam int W    = edts_pkg::WORK_W;
    localparam int PIW  = (MAX_PERIODIC > 1) ? $clog2(MAX_PERIODIC) : 1;
    localparam int AIW  = (MAX_APERIODIC > 1) ? $clog2(MAX_APERIODIC) : 1;
    localparam int MAXN = (MAX_PERIODIC > MAX_APERIODIC) ? MAX_PERIODIC : MAX_APERIODIC;
    localparam int SLW  = (PIW > AIW) ? PIW : AIW;
    localparam int SCW  = $clog2(MAXN + 1);
    localparam int DW   = TIME_BITS + 1;
    localparam int CW   = (DW > W + 1) ? DW : W + 1;
    localparam int TCW  = $clog2(TIME_BITS);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DIV     = 4'd1;
    localparam logic [3:0] ST_SCAN_P  = 4'd2;
    localparam logic [3:0] ST_SCAN_A  = 4'd3;
    localparam logic [3:0] ST_EXEC_RD = 4'd4;
    localparam logic [3:0] ST_EXEC_WR = 4'd5;
    localparam logic [3:0] ST_PRE_RD  = 4'd6;
    localparam logic [3:0] ST_PRE_CHK = 4'd7;
    localparam logic [3:0] ST_DONE    = 4'd8;

    typedef struct packed {
        logic [W-1:0]  work;
        logic [W-1:0]  period;
        logic [W-1:0]  left;
        logic [W-1:0]  rem;
        logic [DW-1:0] deadline;
    } pent_t;

    typedef struct packed {
        logic [W-1:0] work;
        logic [W-1:0] rel_tick;
        logic [W-1:0] left;
    } aent_t;

    // Memories
    pent_t pmem [MAX_PERIODIC];
    aent_t amem [MAX_APERIODIC];
    pent_t p_rdata;
    aent_t a_rdata;
    logic  p_we, a_we;
    logic [PIW-1:0] p_waddr, p_raddr;
    logic [AIW-1:0] a_waddr, a_raddr;
    pent_t p_wdata;
    aent_t a_wdata;

    // Control registers
    logic [3:0]                  state_reg, state_next;
    logic [edts_pkg::COUNT_W-1:0] np_cnt_reg, np_cnt_next, na_cnt_reg, na_cnt_next;
    logic [edts_pkg::CFG_W-1:0]  sim_len_reg, sim_len_next, win_reg, win_next;
    logic [TIME_BITS-1:0]        tick_reg, tick_next;
    logic [MAX_PERIODIC-1:0]     pact_reg, pact_next;
    logic [MAX_APERIODIC-1:0]    aact_reg, aact_next;
    logic [1:0]                  prev_mode_reg, prev_mode_next;
    logic                        prev_aper_reg, prev_aper_next;
    logic [SLW-1:0]              prev_slot_reg, prev_slot_next;
    logic [SCW-1:0]              scan_reg, scan_next, proc_reg, proc_next;
    logic                        proc_v_reg, proc_v_next;
    logic                        found_reg, found_next;
    logic                        ch_aper_reg, ch_aper_next;
    logic [SLW-1:0]              ch_slot_reg, ch_slot_next;
    logic [CW-1:0]               best_reg, best_next;
    logic [edts_pkg::MISS_W-1:0] miss_reg, miss_next;
    logic                        fin_reg, fin_next;
    logic                        pre_v_reg, pre_v_next;
    logic [W-1:0]                pre_left_reg, pre_left_next;
    logic [TCW-1:0]              div_cnt_reg, div_cnt_next;
    logic                        m_valid_reg, m_valid_next;

    // Payload registers
    logic [edts_pkg::SLOT_W-1:0]     ld_slot_reg;
    logic [W-1:0]                    ld_work_reg, ld_por_reg;
    logic [W-1:0]                    div_rem_reg, div_rem_next;
    logic [edts_pkg::OUT_DATA_W-1:0] m_data_reg;

    // Input unpacking
    logic                        in_action, in_aper;
    logic [edts_pkg::SLOT_W-1:0] in_slot;
    logic [W-1:0]                in_work, in_por;
    logic                        s_accept;

    // Scan and result helpers
    logic                        p_inuse, p_rel, p_act;
    logic [DW-1:0]               p_dl;
    logic [W-1:0]                p_rem_inc;
    logic [TIME_BITS-1:0]        tick_inc;
    logic                        a_inuse, a_act;
    logic [W:0]                  a_sum, a_dl;
    logic [W:0]                  div_t;
    logic [W-1:0]                exec_left, pre_left_rd;
    logic                        same_task;
    logic [edts_pkg::CODE_W-1:0] res_code;
    logic                        done_load;
    logic [edts_pkg::OUT_DATA_W-1:0] res_word;

    assign in_action = s_axis_tuser[0];
    assign in_aper   = s_axis_tuser[1];
    assign in_slot   = s_axis_tdata[2:0];
    assign in_work   = s_axis_tdata[18:3];
    assign in_por    = s_axis_tdata[34:19];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign tick_inc  = tick_reg + 1'b1;
    assign done_load = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    // Entries under scan after their release checks, the divider step and the work left.
    always_comb
    begin
        p_inuse   = int'(proc_reg) < int'(np_cnt_reg);
        p_rel     = p_inuse && (p_rdata.period != '0) && (p_rdata.rem == '0);
        p_act     = p_rel || pact_reg[PIW'(proc_reg)];
        p_dl      = p_rel ? (DW'(tick_reg) + DW'(p_rdata.period)) : p_rdata.deadline;
        p_rem_inc = p_rdata.rem + 1'b1;
        a_inuse   = int'(proc_reg) < int'(na_cnt_reg);
        a_act     = aact_reg[AIW'(proc_reg)] ||
                    (a_inuse && (CW'(tick_reg) >= CW'(a_rdata.rel_tick)) &&
                     (a_rdata.left != '0));
        a_sum     = (W+1)'(a_rdata.rel_tick) + (W+1)'(win_reg);
        a_dl      = (a_sum < (W+1)'(sim_len_reg)) ? a_sum : (W+1)'(sim_len_reg);
        div_t     = {div_rem_reg, tick_reg[div_cnt_reg]};
        if (div_t >= {1'b0, ld_por_reg})
        begin
            div_t = div_t - {1'b0, ld_por_reg};
        end
        exec_left   = ch_aper_reg ? a_rdata.left : p_rdata.left;
        if (exec_left != '0)
        begin
            exec_left = exec_left - 1'b1;
        end
        pre_left_rd = prev_aper_reg ? a_rdata.left : p_rdata.left;
    end

    // Switch classification and result word.
    always_comb
    begin
        case (prev_mode_reg)
            edts_pkg::PREV_IDLE: same_task = !found_reg;
            edts_pkg::PREV_TASK: same_task = found_reg && (prev_aper_reg == ch_aper_reg) &&
                                             (prev_slot_reg == ch_slot_reg);
            default:             same_task = 1'b0;
        endcase
        if (prev_mode_reg == edts_pkg::PREV_PENDING)
        begin
            res_code = edts_pkg::SW_FIRST;
        end
        else if (same_task)
        begin
            res_code = edts_pkg::SW_SAME;
        end
        else if (!found_reg)
        begin
            res_code = edts_pkg::SW_IDLE;
        end
        else
        begin
            res_code = edts_pkg::SW_SWITCH;
        end
        res_word = {3'b000,
                    miss_reg,
                    fin_reg,
                    pre_v_reg ? pre_left_reg : {W{1'b0}},
                    pre_v_reg ? 3'(prev_slot_reg) : 3'b000,
                    pre_v_reg && prev_aper_reg,
                    pre_v_reg,
                    res_code,
                    found_reg ? 3'(ch_slot_reg) : 3'b000,
                    found_reg && ch_aper_reg,
                    found_reg,
                    16'(tick_reg)};
    end

    always_comb
    begin
        state_next     = state_reg;
        np_cnt_next    = np_cnt_reg;
        na_cnt_next    = na_cnt_reg;
        sim_len_next   = sim_len_reg;
        win_next       = win_reg;
        tick_next      = tick_reg;
        pact_next      = pact_reg;
        aact_next      = aact_reg;
        prev_mode_next = prev_mode_reg;
        prev_aper_next = prev_aper_reg;
        prev_slot_next = prev_slot_reg;
        scan_next      = scan_reg;
        proc_next      = proc_reg;
        proc_v_next    = proc_v_reg;
        found_next     = found_reg;
        ch_aper_next   = ch_aper_reg;
        ch_slot_next   = ch_slot_reg;
        best_next      = best_reg;
        miss_next      = miss_reg;
        fin_next       = fin_reg;
        pre_v_next     = pre_v_reg;
        pre_left_next  = pre_left_reg;
        div_cnt_next   = div_cnt_reg;
        div_rem_next   = div_rem_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = p_rdata;
        p_raddr = '0;
        a_we    = 1'b0;
        a_waddr = '0;
        a_wdata = a_rdata;
        a_raddr = '0;

        if (cfg_valid)
        begin
            case (cfg_index)
                edts_pkg::REG_PERIODIC_COUNT:   np_cnt_next  = cfg_data[edts_pkg::COUNT_W-1:0];
                edts_pkg::REG_APERIODIC_COUNT:  na_cnt_next  = cfg_data[edts_pkg::COUNT_W-1:0];
                edts_pkg::REG_SIM_LENGTH:       sim_len_next = cfg_data;
                edts_pkg::REG_APERIODIC_WINDOW: win_next     = cfg_data;
                default:                        win_next     = win_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    if (in_action == edts_pkg::ACT_LOAD)
                    begin
                        if (!in_aper)
                        begin
                            if (int'(in_slot) < MAX_PERIODIC)
                            begin
                                div_rem_next = '0;
                                div_cnt_next = TCW'(TIME_BITS - 1);
                                state_next   = ST_DIV;
                            end
                        end
                        else if (int'(in_slot) < MAX_APERIODIC)
                        begin
                            a_we             = 1'b1;
                            a_waddr          = AIW'(in_slot);
                            a_wdata.work     = in_work;
                            a_wdata.rel_tick = in_por;
                            a_wdata.left     = in_work;
                            aact_next[AIW'(in_slot)] = 1'b0;
                        end
                    end
                    else if (CW'(tick_reg) < CW'(sim_len_reg))
                    begin
                        scan_next  = '0;
                        proc_v_next = 1'b0;
                        found_next = 1'b0;
                        ch_aper_next = 1'b0;
                        ch_slot_next = '0;
                        best_next  = '0;
                        miss_next  = '0;
                        fin_next   = 1'b0;
                        state_next = ST_SCAN_P;
                    end
                end
            end

            // One remainder bit per cycle, most significant tick bit first.
            ST_DIV:
            begin
                div_rem_next = div_t[W-1:0];
                if (div_cnt_reg == '0)
                begin
                    p_we             = 1'b1;
                    p_waddr          = PIW'(ld_slot_reg);
                    p_wdata.work     = ld_work_reg;
                    p_wdata.period   = ld_por_reg;
                    p_wdata.left     = ld_work_reg;
                    p_wdata.rem      = div_t[W-1:0];
                    p_wdata.deadline = '0;
                    pact_next[PIW'(ld_slot_reg)] = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                end
            end

            // Read slot scan_reg while slot proc_reg is released, chosen and written back.
            ST_SCAN_P:
            begin
                p_raddr     = PIW'(scan_reg);
                proc_next   = scan_reg;
                proc_v_next = 1'b1;
                scan_next   = scan_reg + 1'b1;
                if (proc_v_reg)
                begin
                    p_we    = 1'b1;
                    p_waddr = PIW'(proc_reg);
                    if (p_rel)
                    begin
                        p_wdata.left     = p_rdata.work;
                        p_wdata.deadline = p_dl;
                        if (pact_reg[PIW'(proc_reg)] && (p_rdata.left != '0) &&
                            (int'(proc_reg) < edts_pkg::MISS_W))
                        begin
                            miss_next[3'(proc_reg)] = 1'b1;
                        end
                    end
                    // The tick after a wrap restarts every phase at zero.
                    if ((tick_inc == '0) || (p_rem_inc == p_rdata.period))
                    begin
                        p_wdata.rem = '0;
                    end
                    else
                    begin
                        p_wdata.rem = p_rem_inc;
                    end
                    pact_next[PIW'(proc_reg)] = p_act;
                    if (p_inuse && p_act && (!found_reg || (CW'(p_dl) < best_reg)))
                    begin
                        found_next   = 1'b1;
                        ch_aper_next = 1'b0;
                        ch_slot_next = SLW'(proc_reg);
                        best_next    = CW'(p_dl);
                    end
                end
                if (scan_reg == SCW'(MAX_PERIODIC))
                begin
                    scan_next   = '0;
                    proc_v_next = 1'b0;
                    state_next  = ST_SCAN_A;
                end
            end

            ST_SCAN_A:
            begin
                a_raddr     = AIW'(scan_reg);
                proc_next   = scan_reg;
                proc_v_next = 1'b1;
                scan_next   = scan_reg + 1'b1;
                if (proc_v_reg)
                begin
                    aact_next[AIW'(proc_reg)] = a_act;
                    if (a_inuse && a_act && (!found_reg || (CW'(a_dl) < best_reg)))
                    begin
                        found_next   = 1'b1;
                        ch_aper_next = 1'b1;
                        ch_slot_next = SLW'(proc_reg);
                        best_next    = CW'(a_dl);
                    end
                end
                if (scan_reg == SCW'(MAX_APERIODIC))
                begin
                    proc_v_next = 1'b0;
                    state_next  = ST_EXEC_RD;
                end
            end

            ST_EXEC_RD:
            begin
                p_raddr    = PIW'(ch_slot_reg);
                a_raddr    = AIW'(ch_slot_reg);
                state_next = found_reg ? ST_EXEC_WR : ST_PRE_RD;
            end

            ST_EXEC_WR:
            begin
                if (ch_aper_reg)
                begin
                    a_we         = 1'b1;
                    a_waddr      = AIW'(ch_slot_reg);
                    a_wdata.left = exec_left;
                end
                else
                begin
                    p_we         = 1'b1;
                    p_waddr      = PIW'(ch_slot_reg);
                    p_wdata.left = exec_left;
                end
                if (exec_left == '0)
                begin
                    fin_next = 1'b1;
                    if (ch_aper_reg)
                    begin
                        aact_next[AIW'(ch_slot_reg)] = 1'b0;
                    end
                    else
                    begin
                        pact_next[PIW'(ch_slot_reg)] = 1'b0;
                    end
                end
                state_next = ST_PRE_RD;
            end

            ST_PRE_RD:
            begin
                p_raddr = PIW'(prev_slot_reg);
                a_raddr = AIW'(prev_slot_reg);
                if ((prev_mode_reg == edts_pkg::PREV_TASK) && !same_task)
                begin
                    state_next = ST_PRE_CHK;
                end
                else
                begin
                    pre_v_next    = 1'b0;
                    pre_left_next = '0;
                    state_next    = ST_DONE;
                end
            end

            ST_PRE_CHK:
            begin
                pre_left_next = pre_left_rd;
                pre_v_next    = (pre_left_rd != '0);
                state_next    = ST_DONE;
            end

            ST_DONE:
            begin
                if (done_load)
                begin
                    m_valid_next   = 1'b1;
                    prev_mode_next = found_reg ? edts_pkg::PREV_TASK : edts_pkg::PREV_IDLE;
                    prev_aper_next = found_reg && ch_aper_reg;
                    prev_slot_next = found_reg ? ch_slot_reg : '0;
                    tick_next      = tick_inc;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            pmem[p_waddr] <= p_wdata;
        end
        p_rdata <= pmem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            amem[a_waddr] <= a_wdata;
        end
        a_rdata <= amem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ld_slot_reg <= in_slot;
            ld_work_reg <= in_work;
            ld_por_reg  <= in_por;
        end
        div_rem_reg <= div_rem_next;
        if (done_load)
        begin
            m_data_reg <= res_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            np_cnt_reg    <= '0;
            na_cnt_reg    <= '0;
            sim_len_reg   <= edts_pkg::SIM_LENGTH_RESET;
            win_reg       <= edts_pkg::APERIODIC_WINDOW_RESET;
            tick_reg      <= '0;
            pact_reg      <= '0;
            aact_reg      <= '0;
            prev_mode_reg <= edts_pkg::PREV_PENDING;
            prev_aper_reg <= 1'b0;
            prev_slot_reg <= '0;
            scan_reg      <= '0;
            proc_reg      <= '0;
            proc_v_reg    <= 1'b0;
            found_reg     <= 1'b0;
            ch_aper_reg   <= 1'b0;
            ch_slot_reg   <= '0;
            best_reg      <= '0;
            miss_reg      <= '0;
            fin_reg       <= 1'b0;
            pre_v_reg     <= 1'b0;
            pre_left_reg  <= '0;
            div_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            np_cnt_reg    <= np_cnt_next;
            na_cnt_reg    <= na_cnt_next;
            sim_len_reg   <= sim_len_next;
            win_reg       <= win_next;
            tick_reg      <= tick_next;
            pact_reg      <= pact_next;
            aact_reg      <= aact_next;
            prev_mode_reg <= prev_mode_next;
            prev_aper_reg <= prev_aper_next;
            prev_slot_reg <= prev_slot_next;
            scan_reg      <= scan_next;
            proc_reg      <= proc_next;
            proc_v_reg    <= proc_v_next;
            found_reg     <= found_next;
            ch_aper_reg   <= ch_aper_next;
            ch_slot_reg   <= ch_slot_next;
            best_reg      <= best_next;
            miss_reg      <= miss_next;
            fin_reg       <= fin_next;
            pre_v_reg     <= pre_v_next;
            pre_left_reg  <= pre_left_next;
            div_cnt_reg   <= div_cnt_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    `EDTS_CHECK_NEXT(a_tick_step, done_load, tick_reg == TIME_BITS'($past(tick_reg) + 1'b1), "tick did not advance by one with a result beat")
    `EDTS_CHECK_NOW(a_idle_code, done_load && !found_reg, res_code != edts_pkg::SW_SWITCH, "switch reported on an idle tick")
    `EDTS_CHECK_NOW(a_preempt_code, done_load && pre_v_reg, (res_code == edts_pkg::SW_IDLE) || (res_code == edts_pkg::SW_SWITCH), "preemption without a change of task")
    `EDTS_CHECK_NOW(a_finish_clears, done_load && fin_reg, !(ch_aper_reg ? aact_reg[AIW'(ch_slot_reg)] : pact_reg[PIW'(ch_slot_reg)]), "finished task still active")

endmodule
